/* hw/rtl/wsd_pkg.sv */
// Shared types, codes and helper functions of the WebSocket frame deframer.
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR0,
        PH_HDR1,
        PH_MASK,
        PH_PAY
    } t_phase;

    // Frame opcodes (opcode zero marks a frame that is read but refused)
    localparam logic [3:0] OP_NONE   = 4'h0;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Result channels
    localparam logic [1:0] CH_DELIVER = 2'd0;
    localparam logic [1:0] CH_TX      = 2'd1;
    localparam logic [1:0] CH_DROP    = 2'd2;

    // Drop reasons
    localparam logic [2:0] RSN_NONE     = 3'd0;
    localparam logic [2:0] RSN_HEADER   = 3'd1;
    localparam logic [2:0] RSN_EXT_LEN  = 3'd2;
    localparam logic [2:0] RSN_BIN_LEN  = 3'd3;
    localparam logic [2:0] RSN_CLOSE    = 3'd4;

    // Input commands
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Configuration register indexes
    localparam logic CFG_LEN_A = 1'b0;
    localparam logic CFG_LEN_B = 1'b1;

    // Header bytes of frames sent back to the peer (FIN set, no mask)
    localparam logic [7:0] HDR_PONG  = 8'h8A;
    localparam logic [7:0] HDR_CLOSE = 8'h88;

    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0] out_channel;
        logic [7:0] out_byte;
        logic       out_last;
        logic [2:0] drop_reason;
    } t_result;

    typedef struct packed {
        logic [1:0]             count;
        t_result [MAX_RESULTS-1:0] res;
    } t_bundle;

    function automatic t_result mk_tx(input logic [7:0] tx_byte, input logic last);
        t_result r;
        r.out_channel = CH_TX;
        r.out_byte    = tx_byte;
        r.out_last    = last;
        r.drop_reason = RSN_NONE;
        return r;
    endfunction

    function automatic t_result mk_drop(input logic [2:0] reason);
        t_result r;
        r.out_channel = CH_DROP;
        r.out_byte    = 8'h00;
        r.out_last    = 1'b0;
        r.drop_reason = reason;
        return r;
    endfunction

endpackage

/* hw/rtl/wsd_in_if.sv */
// Input channel: one received byte or a connection-start command per transfer.
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

/* hw/rtl/wsd_out_if.sv */
// Result channel: delivered payload byte, byte to transmit, or connection drop.
interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_channel;
    logic [7:0] out_byte;
    logic       out_last;
    logic [2:0] drop_reason;

    modport source (output valid, output out_channel, output out_byte,
                    output out_last, output drop_reason, input ready);
    modport sink   (input valid, input out_channel, input out_byte,
                    input out_last, input drop_reason, output ready);
endinterface

/* hw/rtl/wsd_cfg_if.sv */
// Configuration write channel: register index and write data.
interface wsd_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [6:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/wsd_parser.sv */
// Frame parser: header checks, mask capture, unmasking and reply generation.
module wsd_parser #(
    parameter int unsigned MAX_SHORT_PAYLOAD = 125
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_command,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [6:0]      i_cfg_data,
    output wsd_pkg::t_bundle o_bundle
);

    localparam logic [6:0] MaxLen = 7'(MAX_SHORT_PAYLOAD);

    wsd_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic [6:0]  r_plen, n_plen;
    logic [6:0]  r_cnt, n_cnt;
    logic [31:0] r_key, n_key;
    logic [6:0]  r_len_a, r_len_b;

    logic       w_hdr_ok;
    logic       w_ext_len;
    logic       w_mask_done;
    logic       w_pay_last;
    logic       w_fin_drop;
    logic [7:0] w_plain;

    assign w_hdr_ok = i_rx_byte[7] &&
                      (r_opcode == wsd_pkg::OP_BINARY || r_opcode == wsd_pkg::OP_CLOSE ||
                       r_opcode == wsd_pkg::OP_PING   || r_opcode == wsd_pkg::OP_PONG);
    assign w_ext_len   = i_rx_byte[6:0] > MaxLen;
    assign w_mask_done = (r_cnt[1:0] == 2'd3);
    assign w_pay_last  = ({1'b0, r_cnt} + 8'd1) >= {1'b0, r_plen};
    // Frame end leads to a drop for refused binary frames and for close
    assign w_fin_drop  = (r_opcode == wsd_pkg::OP_NONE) || (r_opcode == wsd_pkg::OP_CLOSE);
    assign w_plain     = i_rx_byte ^ r_key[{r_cnt[1:0], 3'b000} +: 8];

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_command == wsd_pkg::CMD_START) begin
                n_phase = wsd_pkg::PH_HDR0;
            end else begin
                unique case (r_phase)
                    wsd_pkg::PH_IDLE: n_phase = wsd_pkg::PH_IDLE;
                    wsd_pkg::PH_HDR0: n_phase = wsd_pkg::PH_HDR1;
                    wsd_pkg::PH_HDR1: begin
                        n_phase = (!w_hdr_ok || w_ext_len) ? wsd_pkg::PH_IDLE
                                                           : wsd_pkg::PH_MASK;
                    end
                    wsd_pkg::PH_MASK: begin
                        if (w_mask_done) begin
                            if (r_plen == 7'd0) begin
                                n_phase = w_fin_drop ? wsd_pkg::PH_IDLE : wsd_pkg::PH_HDR0;
                            end else begin
                                n_phase = wsd_pkg::PH_PAY;
                            end
                        end
                    end
                    wsd_pkg::PH_PAY: begin
                        if (w_pay_last) begin
                            n_phase = w_fin_drop ? wsd_pkg::PH_IDLE : wsd_pkg::PH_HDR0;
                        end
                    end
                    default: n_phase = wsd_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // Frame fields and results
    always_comb begin
        logic do_finish;
        logic do_clear;
        do_finish = 1'b0;
        do_clear  = 1'b0;
        n_opcode  = r_opcode;
        n_plen    = r_plen;
        n_cnt     = r_cnt;
        n_key     = r_key;
        o_bundle  = '0;
        if (i_accept) begin
            if (i_command == wsd_pkg::CMD_START) begin
                do_clear = 1'b1;
            end else begin
                unique case (r_phase)
                    wsd_pkg::PH_IDLE: ;
                    wsd_pkg::PH_HDR0: begin
                        n_opcode = i_rx_byte[7] ? i_rx_byte[3:0] : wsd_pkg::OP_NONE;
                    end
                    wsd_pkg::PH_HDR1: begin
                        if (!w_hdr_ok) begin
                            o_bundle.res[0] = wsd_pkg::mk_drop(wsd_pkg::RSN_HEADER);
                            o_bundle.count  = 2'd1;
                            do_clear        = 1'b1;
                        end else if (w_ext_len) begin
                            o_bundle.res[0] = wsd_pkg::mk_drop(wsd_pkg::RSN_EXT_LEN);
                            o_bundle.count  = 2'd1;
                            do_clear        = 1'b1;
                        end else begin
                            n_plen = i_rx_byte[6:0];
                            n_cnt  = 7'd0;
                            n_key  = 32'd0;
                            if (r_opcode == wsd_pkg::OP_BINARY &&
                                i_rx_byte[6:0] != r_len_a && i_rx_byte[6:0] != r_len_b) begin
                                n_opcode = wsd_pkg::OP_NONE;
                            end
                        end
                    end
                    wsd_pkg::PH_MASK: begin
                        n_key = r_key | ({24'd0, i_rx_byte} << {r_cnt[1:0], 3'b000});
                        n_cnt = r_cnt + 7'd1;
                        if (w_mask_done) begin
                            n_cnt = 7'd0;
                            if (r_opcode == wsd_pkg::OP_PING) begin
                                o_bundle.res[0] = wsd_pkg::mk_tx(wsd_pkg::HDR_PONG, 1'b0);
                                o_bundle.res[1] = wsd_pkg::mk_tx({1'b0, r_plen},
                                                                 r_plen == 7'd0);
                                o_bundle.count  = 2'd2;
                            end
                            do_finish = (r_plen == 7'd0);
                        end
                    end
                    wsd_pkg::PH_PAY: begin
                        if (r_opcode == wsd_pkg::OP_BINARY) begin
                            o_bundle.res[0].out_channel = wsd_pkg::CH_DELIVER;
                            o_bundle.res[0].out_byte    = w_plain;
                            o_bundle.res[0].out_last    = w_pay_last;
                            o_bundle.res[0].drop_reason = wsd_pkg::RSN_NONE;
                            o_bundle.count              = 2'd1;
                        end else if (r_opcode == wsd_pkg::OP_PING) begin
                            o_bundle.res[0] = wsd_pkg::mk_tx(w_plain, w_pay_last);
                            o_bundle.count  = 2'd1;
                        end
                        n_cnt     = r_cnt + 7'd1;
                        do_finish = w_pay_last;
                    end
                    default: ;
                endcase
            end
        end
        // Frame end: refused and close frames only reach here with no result pending
        if (do_finish) begin
            do_clear = 1'b1;
            if (r_opcode == wsd_pkg::OP_NONE) begin
                o_bundle.res[0] = wsd_pkg::mk_drop(wsd_pkg::RSN_BIN_LEN);
                o_bundle.count  = 2'd1;
            end else if (r_opcode == wsd_pkg::OP_CLOSE) begin
                o_bundle.res[0] = wsd_pkg::mk_tx(wsd_pkg::HDR_CLOSE, 1'b0);
                o_bundle.res[1] = wsd_pkg::mk_tx(8'h00, 1'b1);
                o_bundle.res[2] = wsd_pkg::mk_drop(wsd_pkg::RSN_CLOSE);
                o_bundle.count  = 2'd3;
            end
        end
        if (do_clear) begin
            n_opcode = wsd_pkg::OP_NONE;
            n_plen   = 7'd0;
            n_cnt    = 7'd0;
            n_key    = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsd_pkg::PH_IDLE;
            r_opcode <= wsd_pkg::OP_NONE;
            r_plen   <= 7'd0;
            r_cnt    <= 7'd0;
            r_key    <= 32'd0;
            r_len_a  <= 7'd6;
            r_len_b  <= 7'd18;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_plen   <= n_plen;
            r_cnt    <= n_cnt;
            r_key    <= n_key;
            if (i_cfg_we && i_cfg_index == wsd_pkg::CFG_LEN_A) begin
                r_len_a <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == wsd_pkg::CFG_LEN_B) begin
                r_len_b <= i_cfg_data;
            end
        end
    end

    // A data byte while idle produces nothing and leaves the parser idle
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_command == wsd_pkg::CMD_DATA && r_phase == wsd_pkg::PH_IDLE)
        |-> (o_bundle.count == 2'd0 && n_phase == wsd_pkg::PH_IDLE))
        else $error("wsd_parser: idle data byte produced a result");

    // Every drop result sends the parser idle
    a_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_bundle.count != 2'd0 &&
         o_bundle.res[0].out_channel == wsd_pkg::CH_DROP)
        |=> (r_phase == wsd_pkg::PH_IDLE))
        else $error("wsd_parser: drop without return to idle");

endmodule

/* hw/rtl/wsd_emitter.sv */
// Result buffer: holds the results of one item and hands them out one per transfer.
module wsd_emitter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wsd_pkg::t_bundle  i_bundle,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output wsd_pkg::t_result  o_head
);

    logic [1:0] r_count, n_count;
    wsd_pkg::t_result [wsd_pkg::MAX_RESULTS-1:0] r_res, n_res;
    logic w_xfer;

    assign o_valid    = (r_count != 2'd0);
    assign w_xfer     = o_valid && i_ready;
    assign o_head     = r_res[0];
    // Take a new bundle once at most the head remains and it leaves now
    assign o_can_load = (r_count == 2'd0) || (r_count == 2'd1 && i_ready);

    always_comb begin
        n_count = r_count;
        n_res   = r_res;
        if (i_load) begin
            n_count = i_bundle.count;
            n_res   = i_bundle.res;
        end else if (w_xfer) begin
            n_count  = r_count - 2'd1;
            n_res[0] = r_res[1];
            n_res[1] = r_res[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Never load over results still waiting behind the head
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_count == 2'd0 || (r_count == 2'd1 && i_ready)))
        else $error("wsd_emitter: bundle loaded over pending results");

    // Drop results carry a reason and nothing else; other results carry no reason
    a_drop_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_head.out_channel == wsd_pkg::CH_DROP) ==
                     (o_head.drop_reason != wsd_pkg::RSN_NONE)) &&
                    (o_head.out_channel != wsd_pkg::CH_DROP ||
                     (o_head.out_byte == 8'h00 && !o_head.out_last)))
        else $error("wsd_emitter: malformed result");

    // A loaded nonempty bundle is offered on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_bundle.count != 2'd0) |=> o_valid)
        else $error("wsd_emitter: loaded results not offered");

endmodule

/* hw/rtl/websocket_frame_deframer.sv */
// Server-side WebSocket deframer top level: frame parser feeding a result buffer.
//
// Takes one received byte (or a connection-start command) per transfer on i_rx and
// produces delivered payload bytes, bytes to send back to the peer, and connection
// drops on o_res. A frame must carry FIN and MASK, opcode binary, close, ping or
// pong, and a 7-bit length up to MAX_SHORT_PAYLOAD; the 4-byte key follows and the
// payload is unmasked on the fly. Binary messages whose length matches one of the
// two configured lengths are delivered with out_last on the final byte; pings are
// echoed as pongs, a close is answered with an empty close and then a drop. After
// any drop, data bytes are ignored until the next connection-start command.
// Throughput is one item per clock while the result buffer can take its results: the
// parser state is registered on each accepted item and the results of an item land
// in a three-entry result buffer. An item that yields two or three results (pong
// header, close reply) holds the input while the buffer drains, one result per
// o_res transfer. Apart from those stalls, input ready stays high while the sink
// keeps taking results. Configuration writes are taken
// in any cycle (index 0: first binary length, index 1: second) and must only be
// issued while no item is in flight.
module websocket_frame_deframer #(
    parameter int unsigned MAX_SHORT_PAYLOAD = 125
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wsd_in_if.sink    i_rx,
    wsd_out_if.source o_res,
    wsd_cfg_if.sink   i_cfg
);

    wsd_pkg::t_bundle w_bundle;
    wsd_pkg::t_result w_head;
    logic             w_can_load;
    logic             w_accept;

    // Accept a byte whenever the result buffer can take its results
    assign i_rx.ready = w_can_load;
    assign w_accept   = i_rx.valid && w_can_load;

    // Registers are always writable
    assign i_cfg.ready = 1'b1;

    wsd_parser #(
        .MAX_SHORT_PAYLOAD (MAX_SHORT_PAYLOAD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_command   (i_rx.command),
        .i_rx_byte   (i_rx.rx_byte),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_bundle    (w_bundle)
    );

    wsd_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_bundle   (w_bundle),
        .o_can_load (w_can_load),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_head     (w_head)
    );

    // Drive the result payload from the buffer head
    assign o_res.out_channel = w_head.out_channel;
    assign o_res.out_byte    = w_head.out_byte;
    assign o_res.out_last    = w_head.out_last;
    assign o_res.drop_reason = w_head.drop_reason;

endmodule

/* verif/websocket_frame_deframer_tb.sv */
// Self-checking testbench of the WebSocket frame deframer: byte stream in, results checked.
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;

    localparam int unsigned MAX_SHORT_PAYLOAD = 125;
    localparam int          SETTLE_CYCLES     = 8;      // results are buffered
    localparam int          LONG_HOLD_CYCLES  = 60;
    localparam int          TIMEOUT_NS        = 2_000_000;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } t_rx_item;

    logic i_clk;
    logic i_rst_n;

    wsd_in_if  rx_if ();
    wsd_out_if res_if ();
    wsd_cfg_if cfg_if ();

    websocket_frame_deframer #(
        .MAX_SHORT_PAYLOAD (MAX_SHORT_PAYLOAD)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Stimulus waiting for the driver, and results the parser model says are due.
    t_rx_item          rx_items_q[$];
    wsd_pkg::t_result  due_results_q[$];

    int fail_count   = 0;
    int queued_items = 0;
    int results_seen = 0;
    int tx_gap       = 0;
    int sink_gap     = 0;
    bit idle_on      = 1'b1;

    // Parser model: its own copy of the frame state and the two permitted lengths.
    wsd_pkg::t_phase parse_state;
    logic [3:0]  f_op;
    logic [6:0]  f_len;
    logic [6:0]  f_cnt;
    logic [31:0] f_key;
    logic [6:0]  len_a;
    logic [6:0]  len_b;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    function automatic void add_result(input logic [1:0] ch, input logic [7:0] data,
                                       input logic last, input logic [2:0] rsn);
        wsd_pkg::t_result r;
        r.out_channel = ch;
        r.out_byte    = data;
        r.out_last    = last;
        r.drop_reason = rsn;
        due_results_q.push_back(r);
    endfunction

    function automatic void clear_frame();
        f_op  = wsd_pkg::OP_NONE;
        f_len = '0;
        f_cnt = '0;
        f_key = '0;
    endfunction

    // Report the drop and fall back to ignoring bytes until the next start.
    function automatic void drop_conn(input logic [2:0] rsn);
        add_result(wsd_pkg::CH_DROP, 8'h00, 1'b0, rsn);
        clear_frame();
        parse_state = wsd_pkg::PH_IDLE;
    endfunction

    // Close out a frame whose last byte (or last key byte, if empty) just arrived.
    function automatic void end_frame();
        if (f_op == wsd_pkg::OP_NONE) begin
            drop_conn(wsd_pkg::RSN_BIN_LEN);
        end else if (f_op == wsd_pkg::OP_CLOSE) begin
            add_result(wsd_pkg::CH_TX, wsd_pkg::HDR_CLOSE, 1'b0, wsd_pkg::RSN_NONE);
            add_result(wsd_pkg::CH_TX, 8'h00, 1'b1, wsd_pkg::RSN_NONE);
            drop_conn(wsd_pkg::RSN_CLOSE);
        end else begin
            clear_frame();
            parse_state = wsd_pkg::PH_HDR0;
        end
    endfunction

    // Advance the model by one accepted input transfer and queue what it produces.
    function automatic void deframe_byte(input logic cmd, input logic [7:0] b);
        logic [6:0] len;
        logic [7:0] data;
        logic       last;
        len = b[6:0];
        if (cmd == wsd_pkg::CMD_START) begin
            clear_frame();
            parse_state = wsd_pkg::PH_HDR0;
            return;
        end
        case (parse_state)
            wsd_pkg::PH_HDR0: begin
                // FIN clear is kept as opcode zero so the second byte rejects it
                f_op        = b[7] ? b[3:0] : wsd_pkg::OP_NONE;
                parse_state = wsd_pkg::PH_HDR1;
            end
            wsd_pkg::PH_HDR1: begin
                if (!b[7] || !(f_op == wsd_pkg::OP_BINARY || f_op == wsd_pkg::OP_CLOSE ||
                               f_op == wsd_pkg::OP_PING || f_op == wsd_pkg::OP_PONG)) begin
                    drop_conn(wsd_pkg::RSN_HEADER);
                end else if (len > MAX_SHORT_PAYLOAD) begin
                    drop_conn(wsd_pkg::RSN_EXT_LEN);
                end else begin
                    f_len = len;
                    f_cnt = '0;
                    f_key = '0;
                    // a binary length that is not permitted is read but never delivered
                    if (f_op == wsd_pkg::OP_BINARY && len != len_a && len != len_b)
                        f_op = wsd_pkg::OP_NONE;
                    parse_state = wsd_pkg::PH_MASK;
                end
            end
            wsd_pkg::PH_MASK: begin
                f_key = f_key | (32'(b) << (8 * f_cnt[1:0]));
                f_cnt = f_cnt + 7'd1;
                if (f_cnt >= 7'd4) begin
                    f_cnt = '0;
                    if (f_op == wsd_pkg::OP_PING) begin
                        add_result(wsd_pkg::CH_TX, wsd_pkg::HDR_PONG, 1'b0,
                                   wsd_pkg::RSN_NONE);
                        add_result(wsd_pkg::CH_TX, {1'b0, f_len}, f_len == 7'd0,
                                   wsd_pkg::RSN_NONE);
                    end
                    if (f_len == 7'd0)
                        end_frame();
                    else
                        parse_state = wsd_pkg::PH_PAY;
                end
            end
            wsd_pkg::PH_PAY: begin
                data = b ^ f_key[8 * f_cnt[1:0] +: 8];
                last = ({1'b0, f_cnt} + 8'd1) >= {1'b0, f_len};
                if (f_op == wsd_pkg::OP_BINARY)
                    add_result(wsd_pkg::CH_DELIVER, data, last, wsd_pkg::RSN_NONE);
                else if (f_op == wsd_pkg::OP_PING)
                    add_result(wsd_pkg::CH_TX, data, last, wsd_pkg::RSN_NONE);
                f_cnt = f_cnt + 7'd1;
                if (last)
                    end_frame();
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued items on the input channel, with random gaps
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_rx_item item;
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            // the model advances exactly when the block takes the transfer
            if (rx_if.valid && rx_if.ready)
                deframe_byte(rx_if.command, rx_if.rx_byte);
            if (!rx_if.valid || rx_if.ready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    rx_if.valid <= 1'b0;
                end else if (rx_items_q.size() != 0) begin
                    item = rx_items_q.pop_front();
                    rx_if.valid   <= 1'b1;
                    rx_if.command <= item.command;
                    rx_if.rx_byte <= item.rx_byte;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        tx_gap = $urandom_range(1, 10);
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result transfer and stall the result channel
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        wsd_pkg::t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (due_results_q.size() == 0) begin
                    $error("unexpected result: channel %0d byte %02h last %0d reason %0d",
                           res_if.out_channel, res_if.out_byte, res_if.out_last,
                           res_if.drop_reason);
                    fail_count++;
                end else begin
                    want = due_results_q.pop_front();
                    if (res_if.out_channel !== want.out_channel) begin
                        $error("out_channel: expected %0d, got %0d",
                               want.out_channel, res_if.out_channel);
                        fail_count++;
                    end
                    if (res_if.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, res_if.out_byte);
                        fail_count++;
                    end
                    if (res_if.out_last !== want.out_last) begin
                        $error("out_last: expected %0d, got %0d",
                               want.out_last, res_if.out_last);
                        fail_count++;
                    end
                    if (res_if.drop_reason !== want.drop_reason) begin
                        $error("drop_reason: expected %0d, got %0d",
                               want.drop_reason, res_if.drop_reason);
                        fail_count++;
                    end
                end
                results_seen++;
                // hold off for a long stretch so the result buffer fills and the
                // input channel has to stall while the driver keeps offering
                if (idle_on && (results_seen == 20 || results_seen == 260))
                    sink_gap = LONG_HOLD_CYCLES;
            end
            if (sink_gap != 0) begin
                sink_gap--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 10);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push(input logic cmd, input logic [7:0] b);
        t_rx_item item;
        item.command = cmd;
        item.rx_byte = b;
        rx_items_q.push_back(item);
        queued_items++;
    endtask

    // Two header bytes, a random key, then n_pay random payload bytes.
    task automatic push_frame(input logic [7:0] hdr0, input logic [7:0] hdr1,
                              input int n_pay);
        push(wsd_pkg::CMD_DATA, hdr0);
        push(wsd_pkg::CMD_DATA, hdr1);
        repeat (4) push(wsd_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
        repeat (n_pay) push(wsd_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
    endtask

    // Random bytes after a drop (ignored by the block), then a fresh connection.
    task automatic restart_conn();
        repeat ($urandom_range(0, 3)) push(wsd_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
        push(wsd_pkg::CMD_START, 8'($urandom_range(0, 255)));
    endtask

    // Header byte one with FIN set and random reserved bits.
    function automatic logic [7:0] fin_hdr(input logic [3:0] op);
        return {1'b1, 3'($urandom_range(0, 7)), op};
    endfunction

    // Mostly well-formed frames with random content, plus broken and noisy ones.
    task automatic gen_traffic(input int n_items);
        int         stop_at;
        int         pick;
        int         len;
        logic [3:0] op;
        stop_at = queued_items + n_items;
        push(wsd_pkg::CMD_START, 8'($urandom_range(0, 255)));
        while (queued_items < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                case ($urandom_range(0, 4))
                    0, 1:    len = len_a;
                    2, 3:    len = len_b;
                    default: len = $urandom_range(0, 12);
                endcase
                push_frame(fin_hdr(wsd_pkg::OP_BINARY), 8'h80 | 8'(len), len);
            end else if (pick < 65) begin
                len = $urandom_range(0, 8);
                push_frame(fin_hdr(wsd_pkg::OP_PING), 8'h80 | 8'(len), len);
            end else if (pick < 75) begin
                len = $urandom_range(0, 8);
                push_frame(fin_hdr(wsd_pkg::OP_PONG), 8'h80 | 8'(len), len);
            end else if (pick < 80) begin
                len = $urandom_range(0, 4);
                push_frame(fin_hdr(wsd_pkg::OP_CLOSE), 8'h80 | 8'(len), len);
                restart_conn();
            end else if (pick < 88) begin
                // extended length marker or missing mask bit on a valid opcode
                case ($urandom_range(0, 3))
                    0:       op = wsd_pkg::OP_BINARY;
                    1:       op = wsd_pkg::OP_CLOSE;
                    2:       op = wsd_pkg::OP_PING;
                    default: op = wsd_pkg::OP_PONG;
                endcase
                push(wsd_pkg::CMD_DATA, fin_hdr(op));
                if ($urandom_range(0, 1) == 0)
                    push(wsd_pkg::CMD_DATA, 8'h80 | 8'($urandom_range(126, 127)));
                else
                    push(wsd_pkg::CMD_DATA, 8'($urandom_range(0, 127)));
                restart_conn();
            end else if (pick < 95) begin
                // raw noise: any header pair, a few bytes, then a restart
                push(wsd_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
                push(wsd_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 8))
                    push(wsd_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
                push(wsd_pkg::CMD_START, 8'($urandom_range(0, 255)));
            end else begin
                // frame cut short by a connection start
                len = $urandom_range(1, 12);
                push(wsd_pkg::CMD_DATA, fin_hdr(wsd_pkg::OP_BINARY));
                push(wsd_pkg::CMD_DATA, 8'h80 | 8'(len));
                repeat ($urandom_range(0, 4 + len - 1))
                    push(wsd_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
                push(wsd_pkg::CMD_START, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Block until every queued item is taken and every due result has come out.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (rx_items_q.size() != 0 || rx_if.valid || due_results_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == wsd_pkg::CFG_LEN_A)
            len_a = val;
        else
            len_b = val;
    endtask

    task automatic set_lengths(input logic [6:0] a, input logic [6:0] b);
        write_reg(wsd_pkg::CFG_LEN_A, a);
        write_reg(wsd_pkg::CFG_LEN_B, b);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        // hold every input at a known value from time zero
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.command = wsd_pkg::CMD_DATA;
        rx_if.rx_byte = 8'h00;
        res_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = wsd_pkg::CFG_LEN_A;
        cfg_if.data   = '0;
        parse_state   = wsd_pkg::PH_IDLE;
        clear_frame();
        len_a = 7'd6;
        len_b = 7'd18;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random traffic against the power-on lengths, then park the parser idle
        // with a header error so the directed part starts from a known state.
        gen_traffic(110);
        push(wsd_pkg::CMD_START, 8'h00);
        push(wsd_pkg::CMD_DATA, 8'h00);
        push(wsd_pkg::CMD_DATA, 8'h00);
        wait_idle();

        // Directed cases with small permitted lengths
        set_lengths(7'd1, 7'd0);
        push(wsd_pkg::CMD_DATA, 8'hFF);                      // ignored while idle
        push(wsd_pkg::CMD_START, 8'hFF);
        push_frame(8'h89, 8'h81, 1);                         // ping echoed as pong
        push_frame(8'h82, 8'h82, 2);                         // binary length refused
        push(wsd_pkg::CMD_START, 8'h00);
        push_frame(8'h88, 8'h80, 0);                         // close, reply, drop
        push(wsd_pkg::CMD_START, 8'h00);
        push(wsd_pkg::CMD_DATA, 8'h02);                      // FIN clear
        push(wsd_pkg::CMD_DATA, 8'h80);
        push(wsd_pkg::CMD_START, 8'h00);
        push(wsd_pkg::CMD_DATA, 8'h82);
        push(wsd_pkg::CMD_DATA, 8'hFF);                      // length 127
        wait_idle();

        // Largest and empty permitted lengths
        set_lengths(7'd125, 7'd0);
        gen_traffic(70);
        wait_idle();

        set_lengths(7'($urandom_range(0, 20)), 7'($urandom_range(0, 20)));
        gen_traffic(110);
        wait_idle();

        // Last stretch runs at full rate on both sides
        set_lengths(7'($urandom_range(0, 12)), 7'd3);
        idle_on = 1'b0;
        gen_traffic(110);
        wait_idle();

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
